@@ src/decimal_glyph_renderer_macros.svh @@
// assertion macros for the decimal glyph renderer
`ifndef DECIMAL_GLYPH_RENDERER_MACROS_SVH
`define DECIMAL_GLYPH_RENDERER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dgr_pkg.sv @@
// package with types, constants and font table of the decimal glyph renderer
`timescale 1ns / 1ps
`default_nettype none
package dgr_pkg;

  localparam int ValueW       = 20;
  localparam int RowW         = 5;
  localparam int ColW         = 6;
  localparam int PatW         = 3;
  localparam int ColorW       = 3;
  localparam int DigitW       = 4;
  localparam int LineW        = 3;
  localparam int GlyphLines   = 5;
  localparam int PanelLastCol = 63;
  localparam int PanelLastRow = 31;
  localparam int GlyphSpan    = 2;
  localparam int RecipTen     = 838861;
  localparam int RecipShift   = 23;
  localparam int ProdW        = 2 * ValueW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_init;
    logic emit_step;
  } dgr_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic none;
    logic last;
  } dgr_status_t;

  function automatic logic [PatW-1:0] font_line(input logic [DigitW-1:0] d,
                                                input logic [LineW-1:0] ln);
    logic [5*PatW-1:0] glyph;
    logic [PatW-1:0]   res;
    case (d)
      4'd0:    glyph = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    glyph = {3'd2, 3'd3, 3'd2, 3'd2, 3'd7};
      4'd2:    glyph = {3'd3, 3'd4, 3'd2, 3'd1, 3'd7};
      4'd3:    glyph = {3'd3, 3'd4, 3'd2, 3'd4, 3'd3};
      4'd4:    glyph = {3'd4, 3'd6, 3'd5, 3'd7, 3'd4};
      4'd5:    glyph = {3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
      4'd6:    glyph = {3'd6, 3'd1, 3'd7, 3'd5, 3'd6};
      4'd7:    glyph = {3'd7, 3'd4, 3'd2, 3'd1, 3'd1};
      4'd8:    glyph = {3'd2, 3'd5, 3'd7, 3'd5, 3'd2};
      4'd9:    glyph = {3'd3, 3'd5, 3'd7, 3'd4, 3'd3};
      default: glyph = '0;
    endcase
    case (ln)
      3'd0:    res = glyph[14:12];
      3'd1:    res = glyph[11:9];
      3'd2:    res = glyph[8:6];
      3'd3:    res = glyph[5:3];
      3'd4:    res = glyph[2:0];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/dgr_datapath.sv @@
// datapath: digit split by reciprocal multiply, digit buffer and glyph row output
`timescale 1ns / 1ps
`default_nettype none
module dgr_datapath #(
  parameter int MAX_DIGITS  = 6,
  parameter int DIGIT_PITCH = 4
) (
  input  logic                        clk,
  input  dgr_pkg::dgr_cmd_t           cmd,
  input  logic [dgr_pkg::ValueW-1:0]  value,
  input  logic [dgr_pkg::RowW-1:0]    top_row,
  input  logic [dgr_pkg::ColW-1:0]    start_offset,
  input  logic [dgr_pkg::ColorW-1:0]  color,
  output dgr_pkg::dgr_status_t        status,
  output logic [dgr_pkg::RowW-1:0]    row,
  output logic [dgr_pkg::ColW-1:0]    column,
  output logic [dgr_pkg::PatW-1:0]    pattern,
  output logic [dgr_pkg::ColorW-1:0]  pixel_color,
  output logic                        last
);
  import dgr_pkg::*;

  localparam int KW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int NW   = $clog2(MAX_DIGITS + 1);
  localparam int OffW = $clog2(PanelLastCol + 1 + DIGIT_PITCH);
  localparam logic [ValueW-1:0] MaxValue = ValueW'(10 ** MAX_DIGITS - 1);
  localparam logic [OffW-1:0] OffLimit = OffW'(PanelLastCol - GlyphSpan);

  logic [ValueW-1:0] v;
  logic [RowW-1:0]   top;
  logic [ColW-1:0]   start_off;
  logic [ColorW-1:0] col_code;
  logic [DigitW-1:0] digits [MAX_DIGITS];
  logic [NW-1:0]     n;
  logic [KW-1:0]     k;
  logic [LineW-1:0]  g;
  logic [OffW-1:0]   off;

  logic [ProdW-1:0]  prod;
  logic [ValueW-1:0] quot;
  logic [ValueW-1:0] quot_ten;
  logic [ValueW-1:0] rem_full;
  logic [RowW:0]     row_sum;
  logic [OffW-1:0]   off_next;
  logic              row_end;
  logic              digit_end;

  // v / 10 via reciprocal, exact for 20-bit values
  assign prod     = ProdW'(v) * ProdW'(RecipTen);
  assign quot     = ValueW'(prod >> RecipShift);
  assign quot_ten = ValueW'((quot << 3) + (quot << 1));
  assign rem_full = v - quot_ten;

  assign row_sum   = {1'b0, top} + (RowW + 1)'(g);
  assign off_next  = off + OffW'(DIGIT_PITCH);
  assign row_end   = (g == LineW'(GlyphLines - 1)) || (row_sum == (RowW + 1)'(PanelLastRow));
  assign digit_end = (k == '0) || (off_next > OffLimit);

  assign status.conv_done = (v == '0);
  assign status.none      = (n == '0) || (OffW'(start_off) > OffLimit);
  assign status.last      = row_end && digit_end;

  assign row         = row_sum[RowW-1:0];
  assign column      = ColW'(OffW'(PanelLastCol) - off);
  assign pattern     = font_line(digits[k], g);
  assign pixel_color = col_code;
  assign last        = status.last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v         <= (value > MaxValue) ? MaxValue : value;
      top       <= top_row;
      start_off <= start_offset;
      col_code  <= color;
      n         <= '0;
    end else if (cmd.conv_step) begin
      digits[n[KW-1:0]] <= rem_full[DigitW-1:0];
      v                 <= quot;
      n                 <= n + NW'(1);
    end
    if (cmd.emit_init) begin
      k   <= KW'(n - NW'(1));
      g   <= '0;
      off <= OffW'(start_off);
    end else if (cmd.emit_step) begin
      if (row_end) begin
        g   <= '0;
        k   <= k - KW'(1);
        off <= off_next;
      end else begin
        g <= g + LineW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/dgr_ctrl.sv @@
// controller state machine: accept, digit conversion and glyph row sequencing
`timescale 1ns / 1ps
`default_nettype none
module dgr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dgr_pkg::dgr_status_t status,
  output dgr_pkg::dgr_cmd_t    cmd,
  output logic                 busy,
  output logic                 strobe
);
  import dgr_pkg::*;

  `include "decimal_glyph_renderer_macros.svh"

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (status.conv_done) state_next = status.none ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = 1'b1;
    strobe = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: begin
        cmd.conv_step = !status.conv_done;
        cmd.emit_init = status.conv_done;
      end
      ST_EMIT: begin
        strobe        = 1'b1;
        cmd.emit_step = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // transfer of a new value always starts a busy period
  `DGR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted value did not raise busy")
  // results of one value come in an unbroken run ending at last
  `DGR_ASSERT_NEXT(a_run_continues, strobe && !status.last, strobe, "glyph row run broken")
  `DGR_ASSERT_NEXT(a_last_ends, strobe && status.last, !strobe && !busy, "run did not end at last")

endmodule
`default_nettype wire

@@ src/decimal_glyph_renderer.sv @@
// top level of the decimal glyph renderer
// a value is taken when start is high and busy low; busy stays high until it is done
// digit split takes out one decimal digit per division step (n, up to MAX_DIGITS)
// then one glyph row result per cycle on strobe, up to 5 * MAX_DIGITS results
// the receiver cannot stall; synchronous active-high rst returns the controller to idle
`timescale 1ns / 1ps
`default_nettype none
module decimal_glyph_renderer #(
  parameter int MAX_DIGITS  = 6,
  parameter int DIGIT_PITCH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dgr_pkg::ValueW-1:0]  value,
  input  logic [dgr_pkg::RowW-1:0]    top_row,
  input  logic [dgr_pkg::ColW-1:0]    start_offset,
  input  logic [dgr_pkg::ColorW-1:0]  color,
  output logic                        strobe,
  output logic [dgr_pkg::RowW-1:0]    row,
  output logic [dgr_pkg::ColW-1:0]    column,
  output logic [dgr_pkg::PatW-1:0]    pattern,
  output logic [dgr_pkg::ColorW-1:0]  pixel_color,
  output logic                        last
);
  import dgr_pkg::*;

  dgr_cmd_t    cmd;
  dgr_status_t status;

  dgr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  dgr_datapath #(
    .MAX_DIGITS  (MAX_DIGITS),
    .DIGIT_PITCH (DIGIT_PITCH)
  ) u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .value        (value),
    .top_row      (top_row),
    .start_offset (start_offset),
    .color        (color),
    .status       (status),
    .row          (row),
    .column       (column),
    .pattern      (pattern),
    .pixel_color  (pixel_color),
    .last         (last)
  );

endmodule
`default_nettype wire
